[hw/rtl/buffer_pool_replacement_defines.svh]
// ---------------------------------------------------------------------------
// buffer pool replacement assertion macros
// shared assertion forms, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef BUFFER_POOL_REPLACEMENT_DEFINES_SVH
`define BUFFER_POOL_REPLACEMENT_DEFINES_SVH

// same-cycle implication
`define BPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpr assertion failed");

// next-cycle implication
`define BPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpr assertion failed");

`endif

[hw/rtl/bpr_pkg.sv]
// ---------------------------------------------------------------------------
// bpr_pkg
// shared codes and types of the buffer pool replacement block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpr_pkg;

  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int PIN_W    = 8;
  localparam int POS_W    = 4;

  localparam logic [FUNC_W-1:0] OP_FETCH  = 3'd0;
  localparam logic [FUNC_W-1:0] OP_NEW    = 3'd1;
  localparam logic [FUNC_W-1:0] OP_UNPIN  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_FLUSH  = 3'd3;
  localparam logic [FUNC_W-1:0] OP_DELETE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  localparam logic [PIN_W-1:0] PIN_MAX = '1;
  localparam logic [PIN_W-1:0] PIN_ONE = 8'd1;

  // request info the shared unit needs
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              mark;
  } op_t;

  // compare result and updated entry flags
  typedef struct packed {
    logic             match;
    logic [PIN_W-1:0] pin;
    logic             dirty;
  } upd_t;

endpackage

[hw/rtl/bpr_unit.sv]
// ---------------------------------------------------------------------------
// bpr_unit
// shared id compare and pin / dirty update for one directory entry
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpr_unit import bpr_pkg::*; #(
  parameter int ID_BITS = 16
) (
  input  logic [ID_BITS-1:0] ent_id,
  input  logic [PIN_W-1:0]   ent_pin,
  input  logic               ent_dirty,
  input  logic [ID_BITS-1:0] key_id,
  input  op_t                op,
  output upd_t               upd
);

  always_comb begin
    upd.match = (ent_id == key_id);
    upd.pin   = ent_pin;
    upd.dirty = ent_dirty;
    case (op.func)
      OP_FETCH: begin
        // pin with saturation
        if (ent_pin != PIN_MAX) begin
          upd.pin = ent_pin + PIN_ONE;
        end
      end
      OP_UNPIN: begin
        if (ent_pin != '0) begin
          upd.pin = ent_pin - PIN_ONE;
        end
        upd.dirty = ent_dirty | op.mark;
      end
      OP_FLUSH: begin
        upd.dirty = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/buffer_pool_replacement.sv]
// ---------------------------------------------------------------------------
// buffer_pool_replacement
// recency-ordered page directory with pin counts, dirty marks and
// selectable lru / mru victim choice on a fetch miss
// ---------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------
//   in        start & !busy          in_func, in_page_id, in_mark_dirty
//   out       out_valid (1 cycle)    out_status, out_was_hit, out_slot_pos,
//                                    out_pin_now, out_write_back
//   cfg       cfg_valid & cfg_ready  cfg_replace_mode
//
// one shared compare/update unit walks the entry memory one entry at a time
// (read, then compare and write back) through the single read port; new page
// and early exits answer from idle; fetch / unpin / flush walk to the match
// (or all used entries on a miss); a fetch hit off the front then moves the
// entries above it one back and itself to the front; delete walks all used
// entries; the result beat shows in the cycle after the last step
// rst_n is synchronous; it empties the pool and selects lru, no clearing pass
// results cannot be stalled: out_valid is a one-cycle strobe
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "buffer_pool_replacement_defines.svh"

module buffer_pool_replacement import bpr_pkg::*; #(
  parameter int POOL_SLOTS = 16,
  parameter int ID_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // request beat
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [15:0]         in_page_id,
  input  logic                in_mark_dirty,
  // result beat
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_was_hit,
  output logic [POS_W-1:0]    out_slot_pos,
  output logic [PIN_W-1:0]    out_pin_now,
  output logic                out_write_back,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_replace_mode
);

  localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CNT_W = $clog2(POOL_SLOTS + 1);
  localparam int ENT_W = ID_BITS + PIN_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_SLOTS);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // wait for a request
  localparam logic [2:0] S_RD    = 3'd1;  // search: read entry
  localparam logic [2:0] S_CMP   = 3'd2;  // search: compare and update
  localparam logic [2:0] S_SHRD  = 3'd3;  // fetch hit: read entry above
  localparam logic [2:0] S_SHWR  = 3'd4;  // fetch hit: move it one down
  localparam logic [2:0] S_FRONT = 3'd5;  // fetch hit: place at the front
  localparam logic [2:0] S_DRD   = 3'd6;  // delete: read entry
  localparam logic [2:0] S_DCMP  = 3'd7;  // delete: keep or drop

  // page id reduced to ID_BITS
  logic [ID_BITS+15:0] key_ext;
  logic [ID_BITS-1:0]  key_in;
  assign key_ext = {{ID_BITS{1'b0}}, in_page_id};
  assign key_in  = key_ext[ID_BITS-1:0];

  // control registers
  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic              mode_r;
  logic              out_valid_r, out_valid_nxt;

  // request and walk registers
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic              mark_r, mark_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic [CNT_W-1:0]  wptr_r, wptr_nxt;
  logic [IDX_W-1:0]  sh_r, sh_nxt;
  logic [ENT_W-1:0]  ent_r, ent_nxt;

  // result registers
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [PIN_W-1:0]    pin_r, pin_nxt;
  logic                wb_r, wb_nxt;

  // entry memory: {id, pin, dirty}
  logic [ENT_W-1:0] mem [POOL_SLOTS];
  logic [ENT_W-1:0] rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [ENT_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  // fields of the entry just read
  logic [ID_BITS-1:0] rd_id;
  logic [PIN_W-1:0]   rd_pin;
  logic               rd_dirty;
  assign rd_id    = rd_data_r[ENT_W-1 -: ID_BITS];
  assign rd_pin   = rd_data_r[PIN_W:1];
  assign rd_dirty = rd_data_r[0];

  // shared compare / update unit
  op_t  op;
  upd_t upd;
  assign op.func = func_r;
  assign op.mark = mark_r;

  bpr_unit #(
    .ID_BITS (ID_BITS)
  ) u_unit (
    .ent_id    (rd_id),
    .ent_pin   (rd_pin),
    .ent_dirty (rd_dirty),
    .key_id    (id_r),
    .op        (op),
    .upd       (upd)
  );

  // walk bookkeeping
  logic [CNT_W-1:0] scan_inc;
  logic             scan_last;
  logic [IDX_W-1:0] scan_idx;
  logic [CNT_W-1:0] used_dec;
  logic [IDX_W-1:0] victim;
  logic [CNT_W-1:0] keep_cnt;
  assign scan_inc  = scan_r + CNT_ONE;
  assign scan_last = (scan_inc == used_r);
  assign scan_idx  = scan_r[IDX_W-1:0];
  assign used_dec  = used_r - CNT_ONE;
  assign victim    = mode_r ? '0 : used_dec[IDX_W-1:0];
  assign keep_cnt  = wptr_r + {{(CNT_W-1){1'b0}}, ~upd.match};

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    func_nxt      = func_r;
    id_nxt        = id_r;
    mark_nxt      = mark_r;
    scan_nxt      = scan_r;
    wptr_nxt      = wptr_r;
    sh_nxt        = sh_r;
    ent_nxt       = ent_r;
    status_nxt    = ST_DONE;
    hit_nxt       = 1'b0;
    pos_nxt       = '0;
    pin_nxt       = '0;
    wb_nxt        = 1'b0;
    rd_addr       = scan_idx;
    mem_we        = 1'b0;
    mem_wa        = scan_idx;
    mem_wd        = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt = in_func;
          id_nxt   = key_in;
          mark_nxt = in_mark_dirty;
          scan_nxt = '0;
          wptr_nxt = '0;
          case (in_func)
            OP_FETCH, OP_UNPIN, OP_FLUSH: begin
              if (used_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = (in_func == OP_FETCH) ? ST_FULL : ST_ABSENT;
              end else begin
                state_nxt = S_RD;
              end
            end
            OP_NEW: begin
              out_valid_nxt = 1'b1;
              if (used_r == CNT_FULL) begin
                status_nxt = ST_FULL;
              end else begin
                // append unpinned and clean at the back
                mem_we   = 1'b1;
                mem_wa   = used_r[IDX_W-1:0];
                mem_wd   = {key_in, {PIN_W{1'b0}}, 1'b0};
                pos_nxt  = used_r[IDX_W-1:0];
                used_nxt = used_r + CNT_ONE;
              end
            end
            OP_DELETE: begin
              if (used_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_ABSENT;
              end else begin
                state_nxt = S_DRD;
              end
            end
            default: begin
              // unused codes answer all zero
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (upd.match) begin
          case (func_r)
            OP_FETCH: begin
              if (scan_idx == '0) begin
                mem_we        = 1'b1;
                mem_wa        = '0;
                mem_wd        = {rd_id, upd.pin, upd.dirty};
                out_valid_nxt = 1'b1;
                hit_nxt       = 1'b1;
                pin_nxt       = upd.pin;
                state_nxt     = S_IDLE;
              end else begin
                ent_nxt   = {rd_id, upd.pin, upd.dirty};
                sh_nxt    = scan_idx;
                state_nxt = S_SHRD;
              end
            end
            default: begin
              // unpin and flush update in place
              mem_we        = 1'b1;
              mem_wa        = scan_idx;
              mem_wd        = {rd_id, upd.pin, upd.dirty};
              out_valid_nxt = 1'b1;
              pos_nxt       = scan_idx;
              pin_nxt       = upd.pin;
              wb_nxt        = (func_r == OP_FLUSH) ? rd_dirty : 1'b0;
              state_nxt     = S_IDLE;
            end
          endcase
        end else if (scan_last) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (func_r == OP_FETCH) begin
            // miss: overwrite the victim in place
            mem_we  = 1'b1;
            mem_wa  = victim;
            mem_wd  = {id_r, PIN_ONE, 1'b0};
            pos_nxt = victim;
            pin_nxt = PIN_ONE;
          end else begin
            status_nxt = ST_ABSENT;
          end
        end else begin
          scan_nxt  = scan_inc;
          state_nxt = S_RD;
        end
      end

      S_SHRD: begin
        rd_addr   = sh_r - IDX_ONE;
        state_nxt = S_SHWR;
      end

      S_SHWR: begin
        mem_we    = 1'b1;
        mem_wa    = sh_r;
        mem_wd    = rd_data_r;
        sh_nxt    = sh_r - IDX_ONE;
        state_nxt = (sh_r == IDX_ONE) ? S_FRONT : S_SHRD;
      end

      S_FRONT: begin
        mem_we        = 1'b1;
        mem_wa        = '0;
        mem_wd        = ent_r;
        out_valid_nxt = 1'b1;
        hit_nxt       = 1'b1;
        pin_nxt       = ent_r[PIN_W:1];
        state_nxt     = S_IDLE;
      end

      S_DRD: begin
        state_nxt = S_DCMP;
      end

      S_DCMP: begin
        // survivors are packed toward the front
        if (!upd.match) begin
          mem_we = 1'b1;
          mem_wa = wptr_r[IDX_W-1:0];
          mem_wd = rd_data_r;
        end
        if (scan_last) begin
          used_nxt      = keep_cnt;
          out_valid_nxt = 1'b1;
          status_nxt    = (keep_cnt == used_r) ? ST_ABSENT : ST_DONE;
          state_nxt     = S_IDLE;
        end else begin
          wptr_nxt  = keep_cnt;
          scan_nxt  = scan_inc;
          state_nxt = S_DRD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_replace_mode;
      end
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    id_r     <= id_nxt;
    mark_r   <= mark_nxt;
    scan_r   <= scan_nxt;
    wptr_r   <= wptr_nxt;
    sh_r     <= sh_nxt;
    ent_r    <= ent_nxt;
    status_r <= status_nxt;
    hit_r    <= hit_nxt;
    pos_r    <= pos_nxt;
    pin_r    <= pin_nxt;
    wb_r     <= wb_nxt;
  end

  // result beat, slot position reported in its low four bits
  logic [IDX_W+POS_W-1:0] pos_ext;
  assign pos_ext = {{POS_W{1'b0}}, pos_r};

  assign busy           = (state_r != S_IDLE);
  assign cfg_ready      = ~busy;
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_was_hit    = hit_r;
  assign out_slot_pos   = pos_ext[POS_W-1:0];
  assign out_pin_now    = pin_r;
  assign out_write_back = wb_r;

  // an accepted request always leads to work or a result beat
  `BPR_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid)
  // no slot only on an empty or a full pool
  `BPR_ASSERT_NOW(a_full_status, out_valid && (out_status == ST_FULL),
                  (used_r == '0) || (used_r == CNT_FULL))
  // a hit always lands at the front and completes
  `BPR_ASSERT_NOW(a_hit_front, out_valid && out_was_hit,
                  (out_slot_pos == '0) && (out_status == ST_DONE) && !busy)

endmodule

[tb/buffer_pool_replacement_test.sv]
// ---------------------------------------------------------------------------
// buffer_pool_replacement_test
// self-checking bench for the page directory: requests are queued by phase,
// driven in random bursts, and every result beat is checked field by field
// against an in-bench shadow of the recency list, pin counts and dirty marks
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module buffer_pool_replacement_test import bpr_pkg::*;;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int POOL_SLOTS     = 16;
  localparam int ID_BITS        = 16;
  // worst single request is a fetch hit at the back: walk plus shift
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int WORKING_IDS    = 10;
  localparam int PIN_PUSH_COUNT = 258;

  localparam logic MODE_LRU = 1'b0;
  localparam logic MODE_MRU = 1'b1;

  // func codes the block ignores
  localparam logic [FUNC_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] OP_SPARE_MID   = 3'd6;
  localparam logic [FUNC_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [15:0]       page_id;
    logic              mark_dirty;
  } page_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                was_hit;
    logic [POS_W-1:0]    slot_pos;
    logic [PIN_W-1:0]    pin_now;
    logic                write_back;
  } page_reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [15:0]         in_page_id = '0;
  logic                in_mark_dirty = 1'b0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_was_hit;
  logic [POS_W-1:0]    out_slot_pos;
  logic [PIN_W-1:0]    out_pin_now;
  logic                out_write_back;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_replace_mode = 1'b0;

  buffer_pool_replacement #(
    .POOL_SLOTS(POOL_SLOTS),
    .ID_BITS   (ID_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_page_id      (in_page_id),
    .in_mark_dirty   (in_mark_dirty),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_was_hit     (out_was_hit),
    .out_slot_pos    (out_slot_pos),
    .out_pin_now     (out_pin_now),
    .out_write_back  (out_write_back),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_replace_mode(cfg_replace_mode)
  );

  always #HALF_PERIOD clk = ~clk;

  // requests waiting to be driven, replies waiting to come back
  page_req_t   page_requests[$];
  page_reply_t predicted_replies[$];

  int fail_count   = 0;
  int stall_cycles = 0;

  // ---------------------------------------------------------------------------
  // shadow of the directory: position 0 is the most recently used entry
  // ---------------------------------------------------------------------------
  logic [15:0]      dir_ids   [POOL_SLOTS];
  logic [PIN_W-1:0] dir_pins  [POOL_SLOTS];
  logic             dir_dirty [POOL_SLOTS];
  int               dir_used = 0;
  logic             dir_mode = MODE_LRU;

  // first match from the front, -1 when the page is not resident
  function automatic int dir_lookup(logic [15:0] id);
    int i;
    for (i = 0; i < dir_used; i++)
      if (dir_ids[i] == id) return i;
    return -1;
  endfunction

  // applies one request to the shadow and returns the reply it must give
  function automatic page_reply_t directory_step(page_req_t req);
    page_reply_t      rep;
    int               at;
    int               i;
    int               kept;
    logic [15:0]      hit_id;
    logic [PIN_W-1:0] hit_pin;
    logic             hit_dirty;
    rep = '0;
    rep.status = ST_DONE;
    case (req.func)
      OP_FETCH: begin
        at = dir_lookup(req.page_id);
        if (at >= 0) begin
          // hit: rotate the entry to the front and pin it, saturating
          hit_id    = dir_ids[at];
          hit_pin   = dir_pins[at];
          hit_dirty = dir_dirty[at];
          for (i = at; i > 0; i--) begin
            dir_ids[i]   = dir_ids[i-1];
            dir_pins[i]  = dir_pins[i-1];
            dir_dirty[i] = dir_dirty[i-1];
          end
          if (hit_pin != PIN_MAX) hit_pin = hit_pin + PIN_ONE;
          dir_ids[0]   = hit_id;
          dir_pins[0]  = hit_pin;
          dir_dirty[0] = hit_dirty;
          rep.was_hit  = 1'b1;
          rep.pin_now  = hit_pin;
        end else if (dir_used == 0) begin
          rep.status = ST_FULL;
        end else begin
          // miss: victim is overwritten in place, no reordering
          at = (dir_mode == MODE_MRU) ? 0 : dir_used - 1;
          dir_ids[at]   = req.page_id;
          dir_pins[at]  = PIN_ONE;
          dir_dirty[at] = 1'b0;
          rep.slot_pos  = at[POS_W-1:0];
          rep.pin_now   = PIN_ONE;
        end
      end
      OP_NEW: begin
        if (dir_used >= POOL_SLOTS) begin
          rep.status = ST_FULL;
        end else begin
          dir_ids[dir_used]   = req.page_id;
          dir_pins[dir_used]  = '0;
          dir_dirty[dir_used] = 1'b0;
          rep.slot_pos        = dir_used[POS_W-1:0];
          dir_used++;
        end
      end
      OP_UNPIN: begin
        at = dir_lookup(req.page_id);
        if (at < 0) begin
          rep.status = ST_ABSENT;
        end else begin
          if (dir_pins[at] != '0) dir_pins[at] = dir_pins[at] - PIN_ONE;
          dir_dirty[at] = dir_dirty[at] | req.mark_dirty;
          rep.slot_pos  = at[POS_W-1:0];
          rep.pin_now   = dir_pins[at];
        end
      end
      OP_FLUSH: begin
        at = dir_lookup(req.page_id);
        if (at < 0) begin
          rep.status = ST_ABSENT;
        end else begin
          rep.write_back = dir_dirty[at];
          dir_dirty[at]  = 1'b0;
          rep.slot_pos   = at[POS_W-1:0];
          rep.pin_now    = dir_pins[at];
        end
      end
      OP_DELETE: begin
        // drop every match and close the gaps, order kept
        kept = 0;
        for (i = 0; i < dir_used; i++) begin
          if (dir_ids[i] != req.page_id) begin
            dir_ids[kept]   = dir_ids[i];
            dir_pins[kept]  = dir_pins[i];
            dir_dirty[kept] = dir_dirty[i];
            kept++;
          end
        end
        if (kept == dir_used) rep.status = ST_ABSENT;
        dir_used = kept;
      end
      default: begin
        // spare codes leave the directory alone and answer all zero
      end
    endcase
    return rep;
  endfunction

  task automatic check_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: request beats feed the shadow, result beats are checked in order
  // ---------------------------------------------------------------------------
  logic        req_taken = 1'b0;
  page_req_t   seen_req;
  page_reply_t want_reply;

  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
      dir_used  = 0;
      dir_mode  = MODE_LRU;
    end else begin
      req_taken <= start && !busy;
      if (out_valid) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: result beat with nothing outstanding, expected none, actual %0h",
                   $time, {out_status, out_was_hit, out_slot_pos, out_pin_now,
                           out_write_back});
          fail_count++;
        end else begin
          want_reply = predicted_replies.pop_front();
          check_field("status", int'(want_reply.status), int'(out_status));
          check_field("was_hit", int'(want_reply.was_hit), int'(out_was_hit));
          check_field("slot_pos", int'(want_reply.slot_pos), int'(out_slot_pos));
          check_field("pin_now", int'(want_reply.pin_now), int'(out_pin_now));
          check_field("write_back", int'(want_reply.write_back), int'(out_write_back));
        end
      end
      if (start && !busy) begin
        seen_req = {in_func, in_page_id, in_mark_dirty};
        predicted_replies = {predicted_replies, directory_step(seen_req)};
      end
      if (cfg_valid && cfg_ready) dir_mode = cfg_replace_mode;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: bursts of back-to-back requests with random gaps in between
  // ---------------------------------------------------------------------------
  page_req_t drive_req;
  int        burst_left = 1;
  int        gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      // beat still held off by busy, keep it steady
    end else if (gap_left != 0) begin
      start         <= 1'b0;
      gap_left      <= gap_left - 1;
      in_func       <= FUNC_W'($urandom);
      in_page_id    <= 16'($urandom);
      in_mark_dirty <= 1'($urandom);
    end else if (page_requests.size() != 0) begin
      drive_req      = page_requests.pop_front();
      start         <= 1'b1;
      in_func       <= drive_req.func;
      in_page_id    <= drive_req.page_id;
      in_mark_dirty <= drive_req.mark_dirty;
      if (burst_left <= 1) begin
        burst_left <= int'($urandom_range(40, 1));
        // a quarter of the bursts run straight into the next one
        gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : int'($urandom_range(8, 1));
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      // nothing queued: junk on the payload must be ignored while start is low
      start         <= 1'b0;
      in_func       <= FUNC_W'($urandom);
      in_page_id    <= 16'($urandom);
      in_mark_dirty <= 1'($urandom);
    end
  end

  // watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("buffer_pool_replacement_test NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_req(input logic [FUNC_W-1:0] func, input logic [15:0] id,
                           input logic mark);
    page_req_t req;
    req.func       = func;
    req.page_id    = id;
    req.mark_dirty = mark;
    page_requests = {page_requests, req};
  endtask

  // block is idle once everything queued went in and every reply came back;
  // the extra cycles cover the tail of the last request
  task automatic wait_pool_idle();
    while (page_requests.size() != 0 || start || predicted_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_replace_mode(input logic mode);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_replace_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid        <= 1'b0;
    cfg_replace_mode <= 1'($urandom);
  endtask

  // random traffic over a small working set so that hits, duplicates and a
  // full pool all come up often; a few ids are fully random
  task automatic queue_random_phase(input int count, input int new_weight);
    logic [15:0] working_ids [WORKING_IDS];
    logic [15:0] id;
    int          n;
    int          roll;
    for (n = 0; n < WORKING_IDS; n++) working_ids[n] = 16'($urandom_range(16'hFFFF, 0));
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99, 0) < 85)
        id = working_ids[$urandom_range(WORKING_IDS - 1, 0)];
      else
        id = 16'($urandom_range(16'hFFFF, 0));
      roll = int'($urandom_range(99, 0));
      if (roll < 2)
        queue_req(FUNC_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), id,
                  1'($urandom));
      else if (roll < 10)
        queue_req(OP_DELETE, id, 1'($urandom));
      else if (roll < 10 + new_weight)
        queue_req(OP_NEW, id, 1'($urandom));
      else if (roll < 22 + new_weight)
        queue_req(OP_FLUSH, id, 1'($urandom));
      else if (roll < 42 + new_weight)
        queue_req(OP_UNPIN, id, 1'($urandom));
      else
        queue_req(OP_FETCH, id, 1'($urandom));
    end
  endtask

  logic [15:0] pinned_id;
  int          k;

  initial begin
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_replace_mode(MODE_LRU);

    // directed: empty pool, absent pages, id extremes, duplicates,
    // unpin at zero, flush clearing the mark, lru victim, spare codes
    queue_req(OP_FETCH,  16'h1234, 1'b0);  // miss on an empty pool
    queue_req(OP_UNPIN,  16'h1234, 1'b1);
    queue_req(OP_FLUSH,  16'h1234, 1'b0);
    queue_req(OP_DELETE, 16'h1234, 1'b0);
    queue_req(OP_NEW,    16'h0000, 1'b0);
    queue_req(OP_NEW,    16'hFFFF, 1'b1);
    queue_req(OP_NEW,    16'h5A5A, 1'b0);
    queue_req(OP_NEW,    16'hA5A5, 1'b0);
    queue_req(OP_FETCH,  16'hFFFF, 1'b0);  // hit off the front
    queue_req(OP_FETCH,  16'hFFFF, 1'b1);  // hit at the front
    queue_req(OP_UNPIN,  16'hFFFF, 1'b1);
    queue_req(OP_UNPIN,  16'hFFFF, 1'b0);
    queue_req(OP_UNPIN,  16'hFFFF, 1'b0);  // already unpinned
    queue_req(OP_FLUSH,  16'hFFFF, 1'b0);  // dirty, write back due
    queue_req(OP_FLUSH,  16'hFFFF, 1'b0);  // now clean
    queue_req(OP_NEW,    16'h5A5A, 1'b0);  // duplicate id
    queue_req(OP_UNPIN,  16'h5A5A, 1'b1);  // acts on the one nearer the front
    queue_req(OP_DELETE, 16'h5A5A, 1'b0);  // both copies go
    queue_req(OP_FETCH,  16'h7777, 1'b0);  // miss replaces the back entry
    queue_req(OP_SPARE_FIRST, 16'hFFFF, 1'b1);
    queue_req(OP_SPARE_MID, 16'h0000, 1'b1);
    queue_req(OP_SPARE_LAST, 16'hFFFF, 1'b0);
    queue_req(OP_FETCH,  16'h0000, 1'b0);
    queue_req(OP_DELETE, 16'hFFFF, 1'b0);
    wait_pool_idle();

    // mru mode: drive one page to pin saturation, then evict it from the front
    write_replace_mode(MODE_MRU);
    pinned_id = 16'($urandom_range(16'hFFFF, 0));
    queue_req(OP_NEW, pinned_id, 1'b0);
    for (k = 0; k < PIN_PUSH_COUNT; k++) queue_req(OP_FETCH, pinned_id, 1'($urandom));
    queue_req(OP_UNPIN, pinned_id, 1'b1);
    queue_req(OP_FLUSH, pinned_id, 1'b0);
    queue_req(OP_FETCH, ~pinned_id, 1'b0);
    queue_req(OP_FLUSH, pinned_id, 1'b0);
    wait_pool_idle();

    // random phases alternate the victim choice; the later two raise the fill pressure
    for (k = 0; k < 4; k++) begin
      write_replace_mode((k % 2 == 0) ? MODE_LRU : MODE_MRU);
      queue_random_phase(280, (k < 2) ? 20 : 30);
      wait_pool_idle();
    end

    if (fail_count == 0) begin
      $display("buffer_pool_replacement_test OK");
    end else begin
      $display("buffer_pool_replacement_test NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/bpr_pkg.sv
hw/rtl/bpr_unit.sv
hw/rtl/buffer_pool_replacement.sv
tb/buffer_pool_replacement_test.sv
